### hdl/fit_pkg.sv
// ============================================================================
// fit_pkg
// Shared types and constants of the frame interval trainer.
// ============================================================================
package fit_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_STARTUP_DELAY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_GUARD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETRAIN_GUARD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRAIN_SAMPLES  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRAIN_SAMPLES = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHANGE_PERCENT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_SMOOTH = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_THROTTLE_SMOOTH = 3'd7;

    // field widths
    localparam int TIME_W   = 32;
    localparam int GUARD_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int CNT_W    = 6;
    localparam int SUM_W    = 22;
    localparam int PCT_W    = 7;
    localparam int SMOOTH_W = 8;
    localparam int CUT_W    = 11;
    localparam int FSUM_W   = 9;   // 10 + smoothness
    localparam int PROD_W   = 25;  // mean * (10 + smoothness)
    localparam int DEV_W    = 23;  // deviation * 100, percent * mean

    // register reset values
    localparam logic [GUARD_W-1:0]  RST_STARTUP_DELAY   = 16'd5000;
    localparam logic [GUARD_W-1:0]  RST_TRAIN_GUARD     = 16'd1000;
    localparam logic [GUARD_W-1:0]  RST_RETRAIN_GUARD   = 16'd2000;
    localparam logic [CNT_W-1:0]    RST_TRAIN_SAMPLES   = 6'd50;
    localparam logic [CNT_W-1:0]    RST_RETRAIN_SAMPLES = 6'd20;
    localparam logic [PCT_W-1:0]    RST_CHANGE_PERCENT  = 7'd20;
    localparam logic [SMOOTH_W-1:0] RST_SMOOTHNESS      = 8'd30;

    // batch limits
    localparam int MIN_BATCH = 3;
    localparam int MAX_BATCH = 63;

    // cutoff arithmetic: q = (2*15e6 + d) / (2*d)
    localparam int FACTOR_BASE = 10;
    localparam int PCT_SCALE   = 100;
    localparam int CUT_NUM2    = 30000000;
    localparam int CUT_MIN_HZ  = 15;
    localparam int CUT_MAX_HZ  = 2047;

    // serial divider
    localparam int DIV_W     = 26;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic load;
        logic guard;
        logic prep;
        logic clear;
        logic take;
        logic mdiv_start;
        logic mean_load;
        logic cut_mul;
        logic cut_start;
        logic cut_load;
        logic cut_sel;   // 0 setpoint, 1 throttle
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic active;
        logic past_guard;
        logic trained;
        logic close;
        logic full;
        logic mean_zero;
        logic div_done;
        logic div_busy;
    } dp_stat_t;

endpackage

### hdl/fit_div.sv
// ============================================================================
// fit_div
// Restoring serial divider, one quotient bit per cycle.
// ============================================================================
module fit_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [fit_pkg::DIV_W-1:0]  num,
    input  logic [fit_pkg::DIV_W-1:0]  den,
    output logic                       busy,
    output logic                       done,
    output logic [fit_pkg::DIV_W-1:0]  quo
);

    localparam int W = fit_pkg::DIV_W;

    logic [W-1:0]                  quo_reg;
    logic [W-1:0]                  rem_reg;
    logic [W-1:0]                  den_reg;
    logic [fit_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;
    logic [W:0]                    shifted;
    logic                          fits;

    assign shifted = {rem_reg, quo_reg[W-1]};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == fit_pkg::DIV_CNT_W'(1));
            if (start)
                cnt_reg <= fit_pkg::DIV_CNT_W'(W);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            if (fits)
                rem_reg <= W'(shifted - {1'b0, den_reg});
            else
                rem_reg <= shifted[W-1:0];
            quo_reg <= {quo_reg[W-2:0], fits};
        end
    end

    assign busy = (cnt_reg != '0);
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

### hdl/fit_dp.sv
// ============================================================================
// fit_dp
// Datapath: configuration, accumulators, guard timer, mean and cutoffs.
// ============================================================================
module fit_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fit_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             new_frame,
    input  logic [fit_pkg::TIME_W-1:0]       time_ms,
    input  logic [fit_pkg::PERIOD_W-1:0]     period_us,
    input  logic                             signal_ok,
    input  logic                             rate_ok,
    input  fit_pkg::dp_cmd_t                 cmd,
    output fit_pkg::dp_stat_t                stat,
    output logic                             trained,
    output logic                             new_mean,
    output logic [fit_pkg::PERIOD_W-1:0]     mean_period_us,
    output logic [fit_pkg::CUT_W-1:0]        setpoint_cutoff_hz,
    output logic [fit_pkg::CUT_W-1:0]        throttle_cutoff_hz
);

    localparam int PW = fit_pkg::PERIOD_W;
    localparam int CW = fit_pkg::CNT_W;
    localparam int SW = fit_pkg::SUM_W;
    localparam int DW = fit_pkg::DIV_W;

    // configuration
    logic [fit_pkg::GUARD_W-1:0]  startup_delay_reg;
    logic [fit_pkg::GUARD_W-1:0]  train_guard_reg;
    logic [fit_pkg::GUARD_W-1:0]  retrain_guard_reg;
    logic [CW-1:0]                train_samples_reg;
    logic [CW-1:0]                retrain_samples_reg;
    logic [fit_pkg::PCT_W-1:0]    change_percent_reg;
    logic [fit_pkg::SMOOTH_W-1:0] sp_smooth_reg;
    logic [fit_pkg::SMOOTH_W-1:0] th_smooth_reg;

    // captured item
    logic                         frame_reg;
    logic [fit_pkg::TIME_W-1:0]   time_reg;
    logic [PW-1:0]                period_reg;
    logic                         sig_reg;
    logic                         rate_reg;

    // state
    logic [SW-1:0]                acc_sum_reg;
    logic [CW-1:0]                acc_count_reg;
    logic [PW-1:0]                acc_min_reg;
    logic [PW-1:0]                acc_max_reg;
    logic [PW-1:0]                mean_reg;
    logic                         trained_reg;
    logic                         new_mean_reg;
    logic [fit_pkg::TIME_W-1:0]   guard_reg;

    // work registers
    logic [PW-1:0]                dev_reg;
    logic [fit_pkg::DEV_W-1:0]    pct_reg;
    logic [fit_pkg::PROD_W-1:0]   d_reg;
    logic [fit_pkg::CUT_W-1:0]    sp_cut_reg;
    logic [fit_pkg::CUT_W-1:0]    th_cut_reg;

    // output registers
    logic                         out_trained_reg;
    logic                         out_new_mean_reg;
    logic [PW-1:0]                out_mean_reg;
    logic [fit_pkg::CUT_W-1:0]    out_sp_reg;
    logic [fit_pkg::CUT_W-1:0]    out_th_reg;

    logic                         item_ok;
    logic [fit_pkg::GUARD_W-1:0]  guard_len;
    logic [fit_pkg::TIME_W-1:0]   guard_sum;
    logic [PW-1:0]                dev;
    logic [fit_pkg::DEV_W-1:0]    dev_scaled;
    logic [CW-1:0]                batch_sel;
    logic [CW-1:0]                batch_limit;
    logic [SW-1:0]                trimmed;
    logic [fit_pkg::SMOOTH_W-1:0] factor;
    logic [fit_pkg::FSUM_W-1:0]   fsum;
    logic                         div_start;
    logic [DW-1:0]                div_num;
    logic [DW-1:0]                div_den;
    logic                         div_busy;
    logic                         div_done;
    logic [DW-1:0]                div_quo;
    logic [fit_pkg::CUT_W-1:0]    cut_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_delay_reg   <= fit_pkg::RST_STARTUP_DELAY;
            train_guard_reg     <= fit_pkg::RST_TRAIN_GUARD;
            retrain_guard_reg   <= fit_pkg::RST_RETRAIN_GUARD;
            train_samples_reg   <= fit_pkg::RST_TRAIN_SAMPLES;
            retrain_samples_reg <= fit_pkg::RST_RETRAIN_SAMPLES;
            change_percent_reg  <= fit_pkg::RST_CHANGE_PERCENT;
            sp_smooth_reg       <= fit_pkg::RST_SMOOTHNESS;
            th_smooth_reg       <= fit_pkg::RST_SMOOTHNESS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fit_pkg::REG_STARTUP_DELAY:   startup_delay_reg   <= cfg_data;
                fit_pkg::REG_TRAIN_GUARD:     train_guard_reg     <= cfg_data;
                fit_pkg::REG_RETRAIN_GUARD:   retrain_guard_reg   <= cfg_data;
                fit_pkg::REG_TRAIN_SAMPLES:   train_samples_reg   <= cfg_data[CW-1:0];
                fit_pkg::REG_RETRAIN_SAMPLES: retrain_samples_reg <= cfg_data[CW-1:0];
                fit_pkg::REG_CHANGE_PERCENT:
                    change_percent_reg <= cfg_data[fit_pkg::PCT_W-1:0];
                fit_pkg::REG_SETPOINT_SMOOTH:
                    sp_smooth_reg <= cfg_data[fit_pkg::SMOOTH_W-1:0];
                fit_pkg::REG_THROTTLE_SMOOTH:
                    th_smooth_reg <= cfg_data[fit_pkg::SMOOTH_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- combinational helpers ----
    assign item_ok   = frame_reg && (time_reg > fit_pkg::TIME_W'(startup_delay_reg));
    assign guard_len = trained_reg ? retrain_guard_reg : train_guard_reg;
    assign guard_sum = time_reg + fit_pkg::TIME_W'(guard_len);

    assign dev = (period_reg > mean_reg) ? (period_reg - mean_reg) : (mean_reg - period_reg);
    assign dev_scaled = fit_pkg::DEV_W'(dev_reg) * fit_pkg::DEV_W'(fit_pkg::PCT_SCALE);

    assign batch_sel = trained_reg ? retrain_samples_reg : train_samples_reg;

    always_comb
    begin
        batch_limit = batch_sel;
        if (batch_sel < CW'(fit_pkg::MIN_BATCH))
            batch_limit = CW'(fit_pkg::MIN_BATCH);
        else if (batch_sel > CW'(fit_pkg::MAX_BATCH))
            batch_limit = CW'(fit_pkg::MAX_BATCH);
    end

    // the batch sum never wraps, so the trimmed sum stays non-negative
    assign trimmed = acc_sum_reg - SW'(acc_min_reg) - SW'(acc_max_reg);

    assign factor = cmd.cut_sel ? th_smooth_reg : sp_smooth_reg;
    assign fsum   = fit_pkg::FSUM_W'(factor) + fit_pkg::FSUM_W'(fit_pkg::FACTOR_BASE);

    assign div_start = cmd.mdiv_start | cmd.cut_start;

    always_comb
    begin
        if (cmd.mdiv_start)
        begin
            div_num = DW'(trimmed);
            div_den = DW'(acc_count_reg - CW'(2));
        end
        else
        begin
            div_num = DW'(d_reg) + DW'(fit_pkg::CUT_NUM2);
            div_den = {d_reg, 1'b0};
        end
    end

    fit_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        if (mean_reg == '0)
            cut_val = fit_pkg::CUT_W'(fit_pkg::CUT_MIN_HZ);
        else if (div_quo > DW'(fit_pkg::CUT_MAX_HZ))
            cut_val = fit_pkg::CUT_W'(fit_pkg::CUT_MAX_HZ);
        else if (div_quo < DW'(fit_pkg::CUT_MIN_HZ))
            cut_val = fit_pkg::CUT_W'(fit_pkg::CUT_MIN_HZ);
        else
            cut_val = div_quo[fit_pkg::CUT_W-1:0];
    end

    // ---- state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sum_reg   <= '0;
            acc_count_reg <= '0;
            acc_min_reg   <= '1;
            acc_max_reg   <= '0;
            mean_reg      <= '0;
            trained_reg   <= 1'b0;
            new_mean_reg  <= 1'b0;
            guard_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
                new_mean_reg <= 1'b0;

            if (cmd.guard && item_ok)
            begin
                if (sig_reg && rate_reg)
                begin
                    // arm once; a sum that wraps to zero stays unarmed
                    if (guard_reg == '0)
                        guard_reg <= guard_sum;
                end
                else
                begin
                    acc_sum_reg   <= '0;
                    acc_count_reg <= '0;
                    acc_min_reg   <= '1;
                    acc_max_reg   <= '0;
                end
            end

            if (cmd.clear)
            begin
                acc_sum_reg   <= '0;
                acc_count_reg <= '0;
                acc_min_reg   <= '1;
                acc_max_reg   <= '0;
            end

            if (cmd.take)
            begin
                acc_sum_reg   <= acc_sum_reg + SW'(period_reg);
                acc_count_reg <= acc_count_reg + 1'b1;
                if (period_reg > acc_max_reg)
                    acc_max_reg <= period_reg;
                if (period_reg < acc_min_reg)
                    acc_min_reg <= period_reg;
            end

            if (cmd.mean_load)
            begin
                mean_reg      <= div_quo[PW-1:0];
                trained_reg   <= 1'b1;
                new_mean_reg  <= 1'b1;
                guard_reg     <= '0;
                acc_sum_reg   <= '0;
                acc_count_reg <= '0;
                acc_min_reg   <= '1;
                acc_max_reg   <= '0;
            end
        end
    end

    // ---- payload registers ----
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            frame_reg  <= new_frame;
            time_reg   <= time_ms;
            period_reg <= period_us;
            sig_reg    <= signal_ok;
            rate_reg   <= rate_ok;
        end
        if (cmd.prep)
        begin
            dev_reg <= dev;
            pct_reg <= fit_pkg::DEV_W'(change_percent_reg) * fit_pkg::DEV_W'(mean_reg);
        end
        if (cmd.cut_mul)
            d_reg <= fit_pkg::PROD_W'(mean_reg) * fit_pkg::PROD_W'(fsum);
        if (cmd.cut_load)
        begin
            if (cmd.cut_sel)
                th_cut_reg <= cut_val;
            else
                sp_cut_reg <= cut_val;
        end
        if (cmd.out_load)
        begin
            out_trained_reg  <= trained_reg;
            out_new_mean_reg <= new_mean_reg;
            out_mean_reg     <= mean_reg;
            out_sp_reg       <= sp_cut_reg;
            out_th_reg       <= th_cut_reg;
        end
    end

    assign stat.active     = item_ok && sig_reg && rate_reg;
    assign stat.past_guard = time_reg > guard_reg;
    assign stat.trained    = trained_reg;
    assign stat.close      = dev_scaled < pct_reg;
    assign stat.full       = acc_count_reg >= batch_limit;
    assign stat.mean_zero  = (mean_reg == '0);
    assign stat.div_done   = div_done;
    assign stat.div_busy   = div_busy;

    assign trained            = out_trained_reg;
    assign new_mean           = out_new_mean_reg;
    assign mean_period_us     = out_mean_reg;
    assign setpoint_cutoff_hz = out_sp_reg;
    assign throttle_cutoff_hz = out_th_reg;

    a_empty_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_count_reg == '0) |->
            (acc_sum_reg == '0 && acc_max_reg == '0 && acc_min_reg == '1))
        else $error("empty batch holds stale accumulator values");

    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_count_reg != '0) |-> (acc_min_reg <= acc_max_reg))
        else $error("batch minimum above maximum");

    a_mean_untrained: assert property (@(posedge clk) disable iff (!rst_n)
        !trained_reg |-> (mean_reg == '0))
        else $error("mean set before first batch");

endmodule

### hdl/fit_ctrl.sv
// ============================================================================
// fit_ctrl
// Sequencer: steps one item through guard, sample, mean and cutoff phases.
// ============================================================================
module fit_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  fit_pkg::dp_stat_t stat,
    output fit_pkg::dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_GUARD    = 4'd1;
    localparam logic [3:0] S_PREP     = 4'd2;
    localparam logic [3:0] S_CLOSE    = 4'd3;
    localparam logic [3:0] S_TAKE     = 4'd4;
    localparam logic [3:0] S_LIMIT    = 4'd5;
    localparam logic [3:0] S_MDIV     = 4'd6;
    localparam logic [3:0] S_CUTMUL   = 4'd7;
    localparam logic [3:0] S_CUTSTART = 4'd8;
    localparam logic [3:0] S_CUTWAIT  = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       cut_sel_reg;
    logic       cut_sel_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [3:0] after_cut;

    // after a cutoff: do the throttle one, or finish
    assign after_cut = cut_sel_reg ? S_OUT : S_CUTMUL;

    always_comb
    begin
        cmd          = '0;
        cmd.cut_sel  = cut_sel_reg;
        state_next   = state_reg;
        cut_sel_next = cut_sel_reg;
        in_stall     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_GUARD;
                end
            end
            S_GUARD:
            begin
                cmd.guard    = 1'b1;
                cut_sel_next = 1'b0;
                state_next   = stat.active ? S_PREP : S_CUTMUL;
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (!stat.past_guard)
                    state_next = S_CUTMUL;
                else if (stat.trained)
                    state_next = S_CLOSE;
                else
                    state_next = S_TAKE;
            end
            S_CLOSE:
            begin
                if (stat.close)
                begin
                    cmd.clear  = 1'b1;
                    state_next = S_CUTMUL;
                end
                else
                    state_next = S_TAKE;
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_LIMIT;
            end
            S_LIMIT:
            begin
                if (stat.full)
                begin
                    cmd.mdiv_start = 1'b1;
                    state_next     = S_MDIV;
                end
                else
                    state_next = S_CUTMUL;
            end
            S_MDIV:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_load = 1'b1;
                    state_next    = S_CUTMUL;
                end
            end
            S_CUTMUL:
            begin
                cmd.cut_mul = 1'b1;
                state_next  = S_CUTSTART;
            end
            S_CUTSTART:
            begin
                if (stat.mean_zero)
                begin
                    // no mean yet: cutoff is the floor value
                    cmd.cut_load = 1'b1;
                    cut_sel_next = 1'b1;
                    state_next   = after_cut;
                end
                else
                begin
                    cmd.cut_start = 1'b1;
                    state_next    = S_CUTWAIT;
                end
            end
            S_CUTWAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.cut_load = 1'b1;
                    cut_sel_next = 1'b1;
                    state_next   = after_cut;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cut_sel_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cut_sel_reg   <= cut_sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_mean_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mean_load |-> stat.div_done)
        else $error("mean loaded without divider result");

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.div_busy)
        else $error("divider still running while idle");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped while stalled");

endmodule

### hdl/frame_interval_trainer.sv
// ============================================================================
// frame_interval_trainer
// Learns the receiver frame interval and derives two filter cutoffs.
//
// Usage: one item per frame event on the input channel (in_valid/in_stall);
// one result per item on the output channel (out_valid/out_stall), in order.
// An item is taken when valid is high and stall is low.
// Configuration registers are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while no item is in flight, as the block
// itself does not enforce this. Once a mean exists, each cutoff runs on the
// shared 26-step serial divider; an item that completes a batch also runs
// the mean division on it. One item is in flight at a time; the next one can
// be taken in the cycle after its result is loaded into the output register.
// A finished result sits in the output register; the next item is taken
// while it waits, and the block holds at the end of that item until the
// output register frees up.
// Reset clears accumulators, mean, trained flag and guard, and restores the
// register defaults; the block comes out of reset idle and ready for an item.
// ============================================================================
module frame_interval_trainer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fit_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fit_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             new_frame,
    input  logic [fit_pkg::TIME_W-1:0]       time_ms,
    input  logic [fit_pkg::PERIOD_W-1:0]     period_us,
    input  logic                             signal_ok,
    input  logic                             rate_ok,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             trained,
    output logic                             new_mean,
    output logic [fit_pkg::PERIOD_W-1:0]     mean_period_us,
    output logic [fit_pkg::CUT_W-1:0]        setpoint_cutoff_hz,
    output logic [fit_pkg::CUT_W-1:0]        throttle_cutoff_hz
);

    fit_pkg::dp_cmd_t  cmd;
    fit_pkg::dp_stat_t stat;

    fit_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fit_dp u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .new_frame          (new_frame),
        .time_ms            (time_ms),
        .period_us          (period_us),
        .signal_ok          (signal_ok),
        .rate_ok            (rate_ok),
        .cmd                (cmd),
        .stat               (stat),
        .trained            (trained),
        .new_mean           (new_mean),
        .mean_period_us     (mean_period_us),
        .setpoint_cutoff_hz (setpoint_cutoff_hz),
        .throttle_cutoff_hz (throttle_cutoff_hz)
    );

endmodule

### sim/tb_frame_interval_trainer.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_frame_interval_trainer
// Self-checking bench for the frame interval trainer. Frame items go in over
// the valid/stall input channel. A cycle-free predictor of the trainer works
// out the result for every accepted item, and each result that comes out is
// compared field by field against the oldest prediction. Directed items cover
// the startup delay, guard arming and wrap, invalid frames, batch ends, close
// samples and batch-length clamping. Random sessions follow under changing
// register settings, with random gaps on both sides. A long output hold-off,
// in a separate test, makes the block stall its input.
// ============================================================================
module tb_frame_interval_trainer;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int RANDOM_ITEMS  = 690;
    localparam int SETTLE_CYCLES = 100;
    localparam int MAX_PRINTS    = 100;

    typedef struct packed {
        logic [fit_pkg::GUARD_W-1:0]  startup_delay;
        logic [fit_pkg::GUARD_W-1:0]  train_guard;
        logic [fit_pkg::GUARD_W-1:0]  retrain_guard;
        logic [fit_pkg::CNT_W-1:0]    train_samples;
        logic [fit_pkg::CNT_W-1:0]    retrain_samples;
        logic [fit_pkg::PCT_W-1:0]    change_pct;
        logic [fit_pkg::SMOOTH_W-1:0] setpoint_smooth;
        logic [fit_pkg::SMOOTH_W-1:0] throttle_smooth;
    } trainer_regs_t;

    typedef struct packed {
        logic                         trained;
        logic                         new_mean;
        logic [fit_pkg::PERIOD_W-1:0] mean;
        logic [fit_pkg::CUT_W-1:0]    setpoint_hz;
        logic [fit_pkg::CUT_W-1:0]    throttle_hz;
    } trainer_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    logic [fit_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [fit_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           new_frame;
    logic [fit_pkg::TIME_W-1:0]     time_ms;
    logic [fit_pkg::PERIOD_W-1:0]   period_us;
    logic                           signal_ok;
    logic                           rate_ok;
    logic                           out_valid;
    logic                           out_stall;
    logic                           trained;
    logic                           new_mean;
    logic [fit_pkg::PERIOD_W-1:0]   mean_period_us;
    logic [fit_pkg::CUT_W-1:0]      setpoint_cutoff_hz;
    logic [fit_pkg::CUT_W-1:0]      throttle_cutoff_hz;

    // predictor state
    trainer_regs_t        regs = {fit_pkg::RST_STARTUP_DELAY, fit_pkg::RST_TRAIN_GUARD,
                                  fit_pkg::RST_RETRAIN_GUARD, fit_pkg::RST_TRAIN_SAMPLES,
                                  fit_pkg::RST_RETRAIN_SAMPLES, fit_pkg::RST_CHANGE_PERCENT,
                                  fit_pkg::RST_SMOOTHNESS, fit_pkg::RST_SMOOTHNESS};
    logic [fit_pkg::SUM_W-1:0]    acc_sum      = '0;
    logic [fit_pkg::CNT_W-1:0]    acc_count    = '0;
    logic [fit_pkg::PERIOD_W-1:0] acc_min      = '1;
    logic [fit_pkg::PERIOD_W-1:0] acc_max      = '0;
    logic [fit_pkg::PERIOD_W-1:0] mean_store   = '0;
    logic                         is_trained   = 1'b0;
    logic [fit_pkg::TIME_W-1:0]   guard_expiry = '0;

    trainer_result_t      expected_results[$];
    int                   errors      = 0;
    int                   results_seen = 0;
    int                   cycle_count = 0;
    int                   recv_wait   = 0;
    int                   hold_cycles = 0;
    bit                   send_idle   = 1'b1;
    bit                   recv_idle   = 1'b1;

    frame_interval_trainer dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .new_frame          (new_frame),
        .time_ms            (time_ms),
        .period_us          (period_us),
        .signal_ok          (signal_ok),
        .rate_ok            (rate_ok),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .trained            (trained),
        .new_mean           (new_mean),
        .mean_period_us     (mean_period_us),
        .setpoint_cutoff_hz (setpoint_cutoff_hz),
        .throttle_cutoff_hz (throttle_cutoff_hz)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic void clear_batch();
        acc_sum   = '0;
        acc_count = '0;
        acc_min   = '1;
        acc_max   = '0;
    endfunction

    function automatic int batch_len(input logic [fit_pkg::CNT_W-1:0] v);
        int n;
        n = int'(v);
        if (n < fit_pkg::MIN_BATCH)
            n = fit_pkg::MIN_BATCH;
        if (n > fit_pkg::MAX_BATCH)
            n = fit_pkg::MAX_BATCH;
        return n;
    endfunction

    // 15e6 / (mean * (10 + smooth)), round half up, clamped
    function automatic logic [fit_pkg::CUT_W-1:0] cutoff_for(
        input logic [fit_pkg::PERIOD_W-1:0] mean,
        input logic [fit_pkg::SMOOTH_W-1:0] smooth);
        longint unsigned d;
        longint unsigned q;
        if (mean == '0)
            return fit_pkg::CUT_W'(fit_pkg::CUT_MIN_HZ);
        d = mean;
        d = d * (fit_pkg::FACTOR_BASE + smooth);
        q = (fit_pkg::CUT_NUM2 + d) / (2 * d);
        if (q < fit_pkg::CUT_MIN_HZ)
            q = fit_pkg::CUT_MIN_HZ;
        if (q > fit_pkg::CUT_MAX_HZ)
            q = fit_pkg::CUT_MAX_HZ;
        return fit_pkg::CUT_W'(q);
    endfunction

    function automatic trainer_result_t predict_trainer(
        input logic                         frame,
        input logic [fit_pkg::TIME_W-1:0]   t,
        input logic [fit_pkg::PERIOD_W-1:0] p,
        input logic                         sig,
        input logic                         rate);
        trainer_result_t r;
        logic            use_it;
        longint unsigned dev;
        longint unsigned band;
        int unsigned     trimmed;
        r.new_mean = 1'b0;
        if (frame && t > regs.startup_delay)
        begin
            if (sig && rate)
            begin
                if (guard_expiry == '0)
                    guard_expiry = t + (is_trained ? regs.retrain_guard : regs.train_guard);
                if (t > guard_expiry)
                begin
                    use_it = 1'b1;
                    if (is_trained)
                    begin
                        if (p > mean_store)
                            dev = p - mean_store;
                        else
                            dev = mean_store - p;
                        band = regs.change_pct;
                        band = band * mean_store;
                        if (dev * fit_pkg::PCT_SCALE < band)
                        begin
                            clear_batch();
                            use_it = 1'b0;
                        end
                    end
                    if (use_it)
                    begin
                        acc_sum   = acc_sum + p;
                        acc_count = acc_count + 1'b1;
                        if (p > acc_max)
                            acc_max = p;
                        if (p < acc_min)
                            acc_min = p;
                        if (acc_count >= batch_len(is_trained ? regs.retrain_samples
                                                              : regs.train_samples))
                        begin
                            trimmed    = acc_sum - acc_min - acc_max;
                            mean_store = fit_pkg::PERIOD_W'(trimmed / (acc_count - 2));
                            clear_batch();
                            is_trained   = 1'b1;
                            guard_expiry = '0;
                            r.new_mean   = 1'b1;
                        end
                    end
                end
            end
            else
            begin
                clear_batch();
            end
        end
        r.trained     = is_trained;
        r.mean        = mean_store;
        r.setpoint_hz = cutoff_for(mean_store, regs.setpoint_smooth);
        r.throttle_hz = cutoff_for(mean_store, regs.throttle_smooth);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_frame(input logic frame, input logic [fit_pkg::TIME_W-1:0] t,
                              input logic [fit_pkg::PERIOD_W-1:0] p, input logic sig,
                              input logic rate);
        int gap;
        gap = send_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        new_frame <= frame;
        time_ms   <= t;
        period_us <= p;
        signal_ok <= sig;
        rate_ok   <= rate;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_trainer(frame, t, p, sig, rate));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [fit_pkg::CFG_IDX_W-1:0] idx,
                             input logic [fit_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // all registers are rewritten on every change of settings
    task automatic load_settings(input trainer_regs_t s);
        wait_idle();
        write_reg(fit_pkg::REG_STARTUP_DELAY, s.startup_delay);
        write_reg(fit_pkg::REG_TRAIN_GUARD, s.train_guard);
        write_reg(fit_pkg::REG_RETRAIN_GUARD, s.retrain_guard);
        write_reg(fit_pkg::REG_TRAIN_SAMPLES, fit_pkg::CFG_DATA_W'(s.train_samples));
        write_reg(fit_pkg::REG_RETRAIN_SAMPLES, fit_pkg::CFG_DATA_W'(s.retrain_samples));
        write_reg(fit_pkg::REG_CHANGE_PERCENT, fit_pkg::CFG_DATA_W'(s.change_pct));
        write_reg(fit_pkg::REG_SETPOINT_SMOOTH, fit_pkg::CFG_DATA_W'(s.setpoint_smooth));
        write_reg(fit_pkg::REG_THROTTLE_SMOOTH, fit_pkg::CFG_DATA_W'(s.throttle_smooth));
        cfg_we <= 1'b0;
        regs = s;
    endtask

    function automatic trainer_regs_t make_regs(input int startup, input int tguard,
                                                input int rguard, input int tsamples,
                                                input int rsamples, input int pct,
                                                input int sp_smooth, input int th_smooth);
        trainer_regs_t s;
        s.startup_delay   = fit_pkg::GUARD_W'(startup);
        s.train_guard     = fit_pkg::GUARD_W'(tguard);
        s.retrain_guard   = fit_pkg::GUARD_W'(rguard);
        s.train_samples   = fit_pkg::CNT_W'(tsamples);
        s.retrain_samples = fit_pkg::CNT_W'(rsamples);
        s.change_pct      = fit_pkg::PCT_W'(pct);
        s.setpoint_smooth = fit_pkg::SMOOTH_W'(sp_smooth);
        s.throttle_smooth = fit_pkg::SMOOTH_W'(th_smooth);
        return s;
    endfunction

    function automatic logic [fit_pkg::CNT_W-1:0] pick_batch();
        case ($urandom_range(0, 7))
            0:       return fit_pkg::CNT_W'($urandom_range(0, fit_pkg::MIN_BATCH - 1));
            1:       return fit_pkg::CNT_W'(fit_pkg::MAX_BATCH);
            2:       return fit_pkg::CNT_W'($urandom_range(fit_pkg::MIN_BATCH,
                                                           fit_pkg::MAX_BATCH));
            default: return fit_pkg::CNT_W'($urandom_range(fit_pkg::MIN_BATCH, 8));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // output side and checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result();
        trainer_result_t want;
        results_seen++;
        if (expected_results.size() == 0)
        begin
            report_mismatch($sformatf("result %0d arrived with nothing expected",
                                      results_seen));
            return;
        end
        want = expected_results.pop_front();
        if (trained !== want.trained)
            report_mismatch($sformatf("result %0d trained %b, want %b",
                                      results_seen, trained, want.trained));
        if (new_mean !== want.new_mean)
            report_mismatch($sformatf("result %0d new_mean %b, want %b",
                                      results_seen, new_mean, want.new_mean));
        if (mean_period_us !== want.mean)
            report_mismatch($sformatf("result %0d mean_period_us %0d, want %0d",
                                      results_seen, mean_period_us, want.mean));
        if (setpoint_cutoff_hz !== want.setpoint_hz)
            report_mismatch($sformatf("result %0d setpoint_cutoff_hz %0d, want %0d",
                                      results_seen, setpoint_cutoff_hz, want.setpoint_hz));
        if (throttle_cutoff_hz !== want.throttle_hz)
            report_mismatch($sformatf("result %0d throttle_cutoff_hz %0d, want %0d",
                                      results_seen, throttle_cutoff_hz, want.throttle_hz));
    endtask

    // stall count is drawn per result and runs down while a result is shown
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                check_result();
                recv_wait = recv_idle ? $urandom_range(0, 14) : 0;
            end
            else if (out_valid && recv_wait != 0)
            begin
                recv_wait--;
            end
            out_stall <= (hold_cycles != 0) || (recv_wait != 0);
        end
    end

    // long output hold-off
    always @(posedge clk)
    begin
        if (hold_cycles != 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_frame_interval_trainer: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // reset settings: idle item, items at or before the startup delay,
    // an invalid frame, then the first valid item arms the guard
    task automatic test_startup_and_idle();
        send_frame(1'b0, 32'hFFFF_FFFF, 16'd65500, 1'b1, 1'b1);
        send_frame(1'b1, 32'd0, 16'd950, 1'b1, 1'b1);
        send_frame(1'b1, 32'd5000, 16'd1000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd5001, 16'd1000, 1'b0, 1'b1);
        send_frame(1'b1, 32'd5002, 16'd1000, 1'b1, 1'b1);
    endtask

    // batch length register below the minimum, period extremes
    task automatic test_first_training();
        load_settings(make_regs(0, 0, 0, 0, 1, 100, 0, 255));
        send_frame(1'b1, 32'd7000, 16'd950, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7001, 16'd65500, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7002, 16'd2000, 1'b1, 1'b1);
    endtask

    // zero retraining guard, close samples, exact percent boundary,
    // invalid frames clearing the batch
    task automatic test_retraining();
        send_frame(1'b1, 32'd7003, 16'd2000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7004, 16'd2000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7005, 16'd4000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7006, 16'd3000, 1'b1, 1'b0);
        send_frame(1'b1, 32'd7007, 16'd3000, 1'b0, 1'b1);
        send_frame(1'b1, 32'd7008, 16'd5000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7009, 16'd65500, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7010, 16'd950, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7011, 16'd4100, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7012, 16'd6000, 1'b1, 1'b1);
        send_frame(1'b1, 32'd7013, 16'd8000, 1'b1, 1'b1);
    endtask

    // guard sum wrapping to zero stays unarmed; wrap to a small expiry
    task automatic test_guard_wrap();
        load_settings(make_regs(16'hFFFF, 10, 16'hFFFF, 3, 63, 0, 255, 0));
        send_frame(1'b1, 32'hFFFF_0001, 16'd1234, 1'b1, 1'b1);
        send_frame(1'b1, 32'hFFFF_FFFF, 16'hAAAA, 1'b1, 1'b1);
        send_frame(1'b1, 32'd65535, 16'h5555, 1'b1, 1'b1);
    endtask

    task automatic test_backpressure();
        load_settings(make_regs(0, 0, 0, 3, 3, 10, 30, 30));
        send_idle   = 1'b0;
        hold_cycles <= 400;
        for (int i = 0; i < 12; i++)
            send_frame(1'b1, 32'd70000 + 3 * i,
                       fit_pkg::PERIOD_W'($urandom_range(950, 65500)), 1'b1, 1'b1);
        wait_idle();
        send_idle = 1'b1;
    endtask

    task automatic test_random_sessions();
        trainer_regs_t s;
        logic [fit_pkg::TIME_W-1:0] t;
        logic   frame;
        logic   sig;
        logic   rate;
        int     counted;
        int     n;
        int     k;
        int     r;
        int     g;
        int     step_max;
        int     base;
        int     span;
        int     pi;
        counted = 0;
        t = 32'd100000;
        while (counted < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0:       s.startup_delay = '0;
                1:       s.startup_delay = '1;
                default: s.startup_delay = fit_pkg::GUARD_W'($urandom_range(0, 3000));
            endcase
            s.train_guard   = ($urandom_range(0, 9) == 0) ?
                              fit_pkg::GUARD_W'(16'hFFFF) :
                              fit_pkg::GUARD_W'($urandom_range(0, 300));
            s.retrain_guard = ($urandom_range(0, 9) == 0) ?
                              fit_pkg::GUARD_W'(16'hFFFF) :
                              fit_pkg::GUARD_W'($urandom_range(0, 300));
            s.train_samples   = pick_batch();
            s.retrain_samples = pick_batch();
            case ($urandom_range(0, 5))
                0:       s.change_pct = '0;
                1:       s.change_pct = fit_pkg::PCT_W'(100);
                default: s.change_pct = fit_pkg::PCT_W'($urandom_range(0, 60));
            endcase
            s.setpoint_smooth = fit_pkg::SMOOTH_W'($urandom);
            s.throttle_smooth = fit_pkg::SMOOTH_W'($urandom);
            load_settings(s);
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);

            g = (s.train_guard > s.retrain_guard) ? int'(s.train_guard)
                                                  : int'(s.retrain_guard);
            step_max = (g > 300) ? g / 16 : ($urandom_range(0, 1) ? 5 : 40);
            base = ($urandom_range(0, 3) == 0) ? $urandom_range(950, 65500)
                                               : $urandom_range(1000, 25000);
            n = $urandom_range(15, 60);
            for (int i = 0; i < n; i++)
            begin
                frame = ($urandom_range(0, 19) != 0);
                k     = $urandom_range(0, 29);
                sig   = !(k == 0 || k == 2);
                rate  = !(k == 1 || k == 2);
                t     = t + $urandom_range(0, step_max);
                if ($urandom_range(0, 99) == 0 && t < 32'hE000_0000)
                    t = t + $urandom_range(0, 1 << 24);
                r = $urandom_range(0, 99);
                if (is_trained && r < 35)
                begin
                    // around the learned mean, straddling the change band
                    span = (int'(mean_store) * (int'(regs.change_pct) + 5)) / 100 + 1;
                    pi   = int'(mean_store) - span + int'($urandom_range(0, 2 * span));
                end
                else if (r < 50)
                begin
                    pi = $urandom_range(950, 65500);
                end
                else
                begin
                    pi = base - base / 8 + int'($urandom_range(0, base / 4));
                end
                if (pi < 950)
                    pi = 950;
                if (pi > 65500)
                    pi = 65500;
                send_frame(frame, t, fit_pkg::PERIOD_W'(pi), sig, rate);
                counted++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        new_frame = 1'b0;
        time_ms   = '0;
        period_us = '0;
        signal_ok = 1'b0;
        rate_ok   = 1'b0;
        out_stall = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_startup_and_idle();
        test_first_training();
        test_retraining();
        test_guard_wrap();
        test_backpressure();
        test_random_sessions();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_frame_interval_trainer: clean");
        else
            $display("tb_frame_interval_trainer: errors");
        $finish;
    end

endmodule
